// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertions, disabled while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ctir_pkg.sv =====
// ----------------------------------------------------------------------------
// ctir_pkg
// Shared widths, register codes and sideband types of the tile index remap.
// ----------------------------------------------------------------------------
package ctir_pkg;

    localparam int MAX_FREQ_BITS = 12;
    localparam int MAX_TIME_BITS = 16;
    localparam int IDX_W         = 28;
    localparam int FREQ_W        = MAX_FREQ_BITS + 1;
    localparam int TIME_W        = MAX_TIME_BITS + 1;
    localparam int DIV_W         = 30;
    localparam int SIDE_W        = 64;
    localparam int PROD_W        = 2 * TIME_W;
    localparam int ADDR_W        = 5;

    localparam logic [2:0] REG_CHUNKING  = 3'd0;
    localparam logic [2:0] REG_FREQ      = 3'd1;
    localparam logic [2:0] REG_TIME      = 3'd2;
    localparam logic [2:0] REG_TILE_FREQ = 3'd3;
    localparam logic [2:0] REG_TILE_TIME = 3'd4;

    typedef struct packed {
        logic              chunking;
        logic [FREQ_W-1:0] nf;
        logic [TIME_W-1:0] nt;
        logic [FREQ_W-1:0] cf;
        logic [TIME_W-1:0] ct;
        logic [DIV_W-1:0]  row;
        logic [DIV_W-1:0]  total;
    } cfg_t;

    typedef struct packed {
        logic [SIDE_W-IDX_W-2:0] pad;
        logic                    beyond;
        logic [IDX_W-1:0]        idx;
    } side1_t;

    typedef struct packed {
        logic [SIDE_W-IDX_W-2-2*TIME_W:0] pad;
        logic [TIME_W-1:0]                tw;
        logic [TIME_W-1:0]                tbase;
        logic                             beyond;
        logic [IDX_W-1:0]                 idx;
    } side2_t;

    typedef struct packed {
        logic [SIDE_W-IDX_W-2-TIME_W-FREQ_W:0] pad;
        logic [FREQ_W-1:0]                     ci;
        logic [TIME_W-1:0]                     tbase;
        logic                                  beyond;
        logic [IDX_W-1:0]                      idx;
    } side3_t;

endpackage

// ===== rtl/ctir_div.sv =====
// ----------------------------------------------------------------------------
// ctir_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
module ctir_div
    import ctir_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [DIV_W-1:0]  in_dividend,
    input  logic [DIV_W-1:0]  in_divisor,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [DIV_W-1:0]  out_quot,
    output logic [DIV_W-1:0]  out_rem,
    output logic [SIDE_W-1:0] out_side
);

    logic [DIV_W-1:0]  v_reg;
    logic [DIV_W-1:0]  r_reg [DIV_W];
    logic [DIV_W-1:0]  q_reg [DIV_W];
    logic [DIV_W-1:0]  d_reg [DIV_W];
    logic [SIDE_W-1:0] s_reg [DIV_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[DIV_W-2:0], in_valid};
        end
    end

    for (genvar k = 0; k < DIV_W; k++) begin : g_stage
        logic [DIV_W-1:0]  r_src, q_src, d_src;
        logic [SIDE_W-1:0] s_src;
        logic [DIV_W:0]    r_sh;
        logic              fit;

        if (k == 0) begin : g_first
            assign r_src = '0;
            assign q_src = in_dividend;
            assign d_src = in_divisor;
            assign s_src = in_side;
        end else begin : g_rest
            assign r_src = r_reg[k-1];
            assign q_src = q_reg[k-1];
            assign d_src = d_reg[k-1];
            assign s_src = s_reg[k-1];
        end

        assign r_sh = {r_src, q_src[DIV_W-1]};
        assign fit  = r_sh >= {1'b0, d_src};

        always_ff @(posedge aclk) begin
            if (en) begin
                r_reg[k] <= fit ? DIV_W'(r_sh - {1'b0, d_src}) : r_sh[DIV_W-1:0];
                q_reg[k] <= {q_src[DIV_W-2:0], fit};
                d_reg[k] <= d_src;
                s_reg[k] <= s_src;
            end
        end
    end

    assign out_valid = v_reg[DIV_W-1];
    assign out_quot  = q_reg[DIV_W-1];
    assign out_rem   = r_reg[DIV_W-1];
    assign out_side  = s_reg[DIV_W-1];

endmodule

// ===== rtl/ctir_cfg.sv =====
// ----------------------------------------------------------------------------
// ctir_cfg
// APB register file, clamped dimensions and registered row and total sizes.
// ----------------------------------------------------------------------------
module ctir_cfg
    import ctir_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic              chunking_reg;
    logic [FREQ_W-1:0] freq_reg;
    logic [TIME_W-1:0] time_reg;
    logic [FREQ_W-1:0] tile_freq_reg;
    logic [TIME_W-1:0] tile_time_reg;
    logic [DIV_W-1:0]  row_reg;
    logic [DIV_W-1:0]  total_reg;
    logic [FREQ_W-1:0] nf, cf_raw, cf;
    logic [TIME_W-1:0] nt, ct_raw, ct;
    logic              wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chunking_reg  <= 1'b0;
            freq_reg      <= FREQ_W'(1024);
            time_reg      <= TIME_W'(1);
            tile_freq_reg <= FREQ_W'(1);
            tile_time_reg <= TIME_W'(1);
        end else if (wr) begin
            case (paddr[4:2])
                REG_CHUNKING:  chunking_reg  <= pwdata[0];
                REG_FREQ:      freq_reg      <= pwdata[FREQ_W-1:0];
                REG_TIME:      time_reg      <= pwdata[TIME_W-1:0];
                REG_TILE_FREQ: tile_freq_reg <= pwdata[FREQ_W-1:0];
                REG_TILE_TIME: tile_time_reg <= pwdata[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_CHUNKING:  prdata = {31'b0, chunking_reg};
            REG_FREQ:      prdata = {{(32-FREQ_W){1'b0}}, freq_reg};
            REG_TIME:      prdata = {{(32-TIME_W){1'b0}}, time_reg};
            REG_TILE_FREQ: prdata = {{(32-FREQ_W){1'b0}}, tile_freq_reg};
            REG_TILE_TIME: prdata = {{(32-TIME_W){1'b0}}, tile_time_reg};
            default:       prdata = '0;
        endcase
    end

    assign nf     = (freq_reg == '0) ? FREQ_W'(1) : freq_reg;
    assign nt     = (time_reg == '0) ? TIME_W'(1) : time_reg;
    assign cf_raw = (tile_freq_reg == '0) ? FREQ_W'(1) : tile_freq_reg;
    assign ct_raw = (tile_time_reg == '0) ? TIME_W'(1) : tile_time_reg;
    assign cf     = (cf_raw < nf) ? cf_raw : nf;
    assign ct     = (ct_raw < nt) ? ct_raw : nt;

    always_ff @(posedge aclk) begin
        row_reg   <= DIV_W'(ct * nf);
        total_reg <= DIV_W'(nt * nf);
    end

    assign cfg.chunking = chunking_reg;
    assign cfg.nf       = nf;
    assign cfg.nt       = nt;
    assign cfg.cf       = cf;
    assign cfg.ct       = ct;
    assign cfg.row      = row_reg;
    assign cfg.total    = total_reg;

endmodule

// ===== rtl/chunked_tile_index_remap.sv =====
// ----------------------------------------------------------------------------
// chunked_tile_index_remap
// Maps a frame index in tiled file order to its row-major array position.
//
// Input beats arrive on s_tvalid/s_tready/s_tdata (frame_index in bits 27:0).
// Result beats leave on m_tvalid/m_tready/m_tdata (array_position in 27:0)
// with m_tuser carrying beyond_end. The user must write the registers
// through the APB port only while no beat is in flight; the block does not
// enforce this. One result per input beat, in order. The pipeline is an
// input register, three 30-stage dividers (tile row, tile column, offset
// in tile), and six multiply and add stages. Throughput is one beat per
// cycle; the rate is set by the single-bit stages of the pipelined dividers,
// each one compare and subtract deep. The whole pipeline advances on one
// enable: when the receiver stalls with a result held in the output register,
// every stage holds and s_tready drops until that beat is taken. Reset clears
// all valid bits and returns the registers to their defaults; the row and
// total size registers take the new values in the cycle after any write.
// ----------------------------------------------------------------------------
module chunked_tile_index_remap
    import ctir_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [31:0]       s_tdata,   // frame_index[27:0], zero pad
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,   // array_position[27:0], zero pad
    output logic [0:0]        m_tuser,   // beyond_end
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

`include "assert_macros.svh"

    cfg_t cfg;
    logic en;

    ctir_cfg u_cfg (
        .aclk, .aresetn, .psel, .penable, .pwrite, .paddr, .pwdata,
        .prdata, .pready, .cfg
    );

    logic             m_tvalid_reg;
    logic [IDX_W-1:0] pos_reg;
    logic             beyond_out_reg;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    // input stage
    logic             s0_v_reg;
    logic [IDX_W-1:0] s0_idx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_v_reg <= 1'b0;
        end else if (en) begin
            s0_v_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s0_idx_reg <= s_tdata[IDX_W-1:0];
        end
    end

    // tile row divide
    side1_t           d1_in_side, d1_out_side;
    logic             d1_v;
    logic [DIV_W-1:0] d1_q, d1_r;

    assign d1_in_side.pad    = '0;
    assign d1_in_side.beyond = {2'b0, s0_idx_reg} >= cfg.total;
    assign d1_in_side.idx    = s0_idx_reg;

    ctir_div u_div_row (
        .aclk, .aresetn, .en,
        .in_valid(s0_v_reg), .in_dividend({2'b0, s0_idx_reg}), .in_divisor(cfg.row),
        .in_side(d1_in_side),
        .out_valid(d1_v), .out_quot(d1_q), .out_rem(d1_r), .out_side(d1_out_side)
    );

    // row base, edge width, tile size
    logic              s2_v_reg, s3_v_reg, s4_v_reg;
    logic [PROD_W-1:0] s2_prod_reg;
    logic [DIV_W-1:0]  s2_rem_reg, s3_rem_reg, s4_rem_reg;
    side1_t            s2_side_reg, s3_side_reg, s4_side_reg;
    logic [TIME_W-1:0] s3_tbase_reg, s4_tbase_reg;
    logic [TIME_W-1:0] s3_tw_reg, s4_tw_reg;
    logic [DIV_W-1:0]  s4_d2_reg;
    logic [PROD_W-1:0] tdiff;

    assign tdiff = {{(PROD_W-TIME_W){1'b0}}, cfg.nt} - s2_prod_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
        end else if (en) begin
            s2_v_reg <= d1_v;
            s3_v_reg <= s2_v_reg;
            s4_v_reg <= s3_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_prod_reg  <= d1_q[TIME_W-1:0] * cfg.ct;
            s2_rem_reg   <= d1_r;
            s2_side_reg  <= d1_out_side;
            s3_tw_reg    <= (tdiff > {{(PROD_W-TIME_W){1'b0}}, cfg.ct}) ?
                            cfg.ct : tdiff[TIME_W-1:0];
            s3_tbase_reg <= s2_prod_reg[TIME_W-1:0];
            s3_rem_reg   <= s2_rem_reg;
            s3_side_reg  <= s2_side_reg;
            s4_d2_reg    <= DIV_W'(s3_tw_reg * cfg.cf);
            s4_tw_reg    <= s3_tw_reg;
            s4_tbase_reg <= s3_tbase_reg;
            s4_rem_reg   <= s3_rem_reg;
            s4_side_reg  <= s3_side_reg;
        end
    end

    // tile column divide
    side2_t           d2_in_side, d2_out_side;
    logic             d2_v;
    logic [DIV_W-1:0] d2_q, d2_r;

    assign d2_in_side.pad    = '0;
    assign d2_in_side.tw     = s4_tw_reg;
    assign d2_in_side.tbase  = s4_tbase_reg;
    assign d2_in_side.beyond = s4_side_reg.beyond;
    assign d2_in_side.idx    = s4_side_reg.idx;

    ctir_div u_div_col (
        .aclk, .aresetn, .en,
        .in_valid(s4_v_reg), .in_dividend(s4_rem_reg), .in_divisor(s4_d2_reg),
        .in_side(d2_in_side),
        .out_valid(d2_v), .out_quot(d2_q), .out_rem(d2_r), .out_side(d2_out_side)
    );

    // offset in tile divide
    side3_t           d3_in_side, d3_out_side;
    logic             d3_v;
    logic [DIV_W-1:0] d3_q, d3_r;

    assign d3_in_side.pad    = '0;
    assign d3_in_side.ci     = d2_q[FREQ_W-1:0];
    assign d3_in_side.tbase  = d2_out_side.tbase;
    assign d3_in_side.beyond = d2_out_side.beyond;
    assign d3_in_side.idx    = d2_out_side.idx;

    ctir_div u_div_off (
        .aclk, .aresetn, .en,
        .in_valid(d2_v), .in_dividend(d2_r),
        .in_divisor({{(DIV_W-TIME_W){1'b0}}, d2_out_side.tw}),
        .in_side(d3_in_side),
        .out_valid(d3_v), .out_quot(d3_q), .out_rem(d3_r), .out_side(d3_out_side)
    );

    // position assembly
    logic                s5_v_reg, s6_v_reg;
    logic [2*FREQ_W-1:0] s5_cmul_reg;
    logic [FREQ_W-1:0]   s5_q_reg, s6_fi_reg;
    logic [TIME_W-1:0]   s5_ti_reg;
    logic [DIV_W-1:0]    s6_tmul_reg;
    logic [IDX_W-1:0]    s5_idx_reg, s6_idx_reg;
    logic                s5_beyond_reg, s6_beyond_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s5_v_reg     <= 1'b0;
            s6_v_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            s5_v_reg     <= d3_v;
            s6_v_reg     <= s5_v_reg;
            m_tvalid_reg <= s6_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s5_cmul_reg    <= d3_out_side.ci * cfg.cf;
            s5_q_reg       <= d3_q[FREQ_W-1:0];
            s5_ti_reg      <= TIME_W'(d3_out_side.tbase + d3_r[TIME_W-1:0]);
            s5_idx_reg     <= d3_out_side.idx;
            s5_beyond_reg  <= d3_out_side.beyond;
            s6_fi_reg      <= FREQ_W'(s5_cmul_reg[FREQ_W-1:0] + s5_q_reg);
            s6_tmul_reg    <= DIV_W'(s5_ti_reg * cfg.nf);
            s6_idx_reg     <= s5_idx_reg;
            s6_beyond_reg  <= s5_beyond_reg;
            pos_reg        <= (cfg.chunking && !s6_beyond_reg) ?
                              IDX_W'(s6_tmul_reg[IDX_W-1:0] +
                                     {{(IDX_W-FREQ_W){1'b0}}, s6_fi_reg}) :
                              s6_idx_reg;
            beyond_out_reg <= s6_beyond_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(32-IDX_W){1'b0}}, pos_reg};
    assign m_tuser  = beyond_out_reg;

    `ASSERT_IMPL(a_stall_holds_input, aclk, aresetn, s0_v_reg && !en,
        ##1 ($stable(s0_idx_reg) && s0_v_reg), "input stage changed during stall")
    `ASSERT_IMPL(a_edge_width_bound, aclk, aresetn,
        s3_v_reg && cfg.chunking && !s3_side_reg.beyond,
        (s3_tw_reg <= cfg.ct) && (s3_tw_reg != '0), "edge tile width out of range")
    `ASSERT_IMPL(a_beyond_passthrough, aclk, aresetn, s6_v_reg && s6_beyond_reg && en,
        ##1 ((pos_reg == $past(s6_idx_reg)) && beyond_out_reg),
        "beyond-end beat not passed through")

endmodule

// ===== tb/ctir_checker.sv =====
// ----------------------------------------------------------------------------
// ctir_checker
// Watches the register port and both streams of the tile index remap,
// predicts each result beat from its own copy of the registers and
// compares it field by field with the beat that leaves the block.
// ----------------------------------------------------------------------------
module ctir_checker
    import ctir_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [31:0]       s_tdata,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [31:0]       m_tdata,
    input  logic [0:0]        m_tuser,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    input  logic              pready,
    output int                mismatches,
    output int                positions_pending
);

    typedef struct {
        logic [IDX_W-1:0] position;
        logic             beyond;
    } position_t;

    position_t        expected_positions[$];
    logic             mode_tiled;
    logic [FREQ_W-1:0] freq_reg;
    logic [TIME_W-1:0] time_reg;
    logic [FREQ_W-1:0] tile_freq_reg;
    logic [TIME_W-1:0] tile_time_reg;

    assign positions_pending = expected_positions.size();

    function automatic longint unsigned floor_one(input longint unsigned v);
        return (v == 0) ? 1 : v;
    endfunction

    function automatic position_t remap_index(input logic [IDX_W-1:0] idx);
        position_t r;
        longint unsigned nf, nt, cf, ct, row, ri, rem, tw, ci, off, fi, ti, pos;
        nf  = floor_one(freq_reg);
        nt  = floor_one(time_reg);
        cf  = floor_one(tile_freq_reg);
        ct  = floor_one(tile_time_reg);
        pos = idx;
        if (cf > nf) begin
            cf = nf;
        end
        if (ct > nt) begin
            ct = nt;
        end
        r.beyond = (idx >= nf * nt);
        if (mode_tiled && !r.beyond) begin
            row = cf * ct * (nf / cf) + (nf % cf) * ct;
            ri  = idx / row;
            rem = idx % row;
            tw  = (nt - ri * ct < ct) ? nt - ri * ct : ct;
            ci  = rem / (tw * cf);
            off = rem - ci * tw * cf;
            fi  = ci * cf + off / tw;
            ti  = ri * ct + off % tw;
            pos = ti * nf + fi;
        end
        r.position = pos[IDX_W-1:0];
        return r;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("error at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        position_t exp_pos;
        if (!aresetn) begin
            mode_tiled    <= 1'b0;
            freq_reg      <= FREQ_W'(1024);
            time_reg      <= TIME_W'(1);
            tile_freq_reg <= FREQ_W'(1);
            tile_time_reg <= TIME_W'(1);
            expected_positions.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[ADDR_W-1:2])
                    REG_CHUNKING:  mode_tiled    <= pwdata[0];
                    REG_FREQ:      freq_reg      <= pwdata[FREQ_W-1:0];
                    REG_TIME:      time_reg      <= pwdata[TIME_W-1:0];
                    REG_TILE_FREQ: tile_freq_reg <= pwdata[FREQ_W-1:0];
                    REG_TILE_TIME: tile_time_reg <= pwdata[TIME_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                expected_positions.insert(expected_positions.size(),
                                          remap_index(s_tdata[IDX_W-1:0]));
            end
            if (m_tvalid && m_tready) begin
                if (expected_positions.size() == 0) begin
                    report("unexpected beat", m_tdata, 32'd0);
                end else begin
                    exp_pos = expected_positions.pop_front();
                    if (m_tdata !== {{(32-IDX_W){1'b0}}, exp_pos.position}) begin
                        report("array_position", m_tdata, 32'(exp_pos.position));
                    end
                    if (m_tuser[0] !== exp_pos.beyond) begin
                        report("beyond_end", 32'(m_tuser), 32'(exp_pos.beyond));
                    end
                end
            end
        end
    end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives frame indices through the tile index remap under a series of
// register settings (defaults, clamped and edge tiles, zero values, the
// largest sizes, pass-through) with random gaps on both streams and one
// long receiver stall; the checker predicts and compares every beat.
// ----------------------------------------------------------------------------
module testbench
    import ctir_pkg::*;
();

    localparam int CYCLE_LIMIT = 2000000;

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [31:0]       s_tdata;   // frame_index[27:0], zero pad
    logic              m_tvalid;
    logic              m_tready;
    logic [31:0]       m_tdata;   // array_position[27:0], zero pad
    logic [0:0]        m_tuser;   // beyond_end
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    int   mismatches;
    int   positions_pending;
    int   cycles;
    logic steady;
    logic hold_request;
    longint unsigned index_span;

    chunked_tile_index_remap u_dut (.*);

    ctir_checker u_checker (.*);

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("chunked_tile_index_remap: mismatch");
            $finish;
        end
    end

    // receiver: random stalls, one long hold-off on request
    initial begin
        logic hold_done;
        hold_done = 1'b0;
        m_tready  = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request && !hold_done) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (400) @(posedge aclk);
            end else begin
                m_tready <= steady || ($urandom_range(99) >= 36);
            end
        end
    end

    task automatic reg_write(input logic [2:0] reg_index, input logic [31:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({reg_index, 2'b00});
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        repeat (3) @(posedge aclk);
    endtask

    task automatic apply_layout(input logic tiled, input int nf, input int nt,
                                input int cf, input int ct);
        longint unsigned f, t;
        reg_write(REG_CHUNKING, 32'(tiled));
        reg_write(REG_FREQ, 32'(nf));
        reg_write(REG_TIME, 32'(nt));
        reg_write(REG_TILE_FREQ, 32'(cf));
        reg_write(REG_TILE_TIME, 32'(ct));
        f = (nf % 8192 == 0) ? 1 : nf % 8192;
        t = (nt % 131072 == 0) ? 1 : nt % 131072;
        index_span = f * t;
    endtask

    task automatic send_index(input logic [IDX_W-1:0] idx);
        logic rdy;
        if (!steady) begin
            while ($urandom_range(99) < 36) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(32-IDX_W){1'b0}}, idx};
        forever begin
            @(negedge aclk);
            rdy = s_tready;
            @(posedge aclk);
            if (rdy) break;
        end
    endtask

    function automatic logic [IDX_W-1:0] pick_index();
        int sel;
        longint unsigned top;
        sel = $urandom_range(99);
        top = (index_span > (1 << IDX_W)) ? (1 << IDX_W) : index_span;
        if (sel < 70) begin
            return IDX_W'({$urandom, $urandom} % top);
        end else if (sel < 85) begin
            return IDX_W'(top - 1 - $urandom_range(3));
        end else if (sel < 92) begin
            return IDX_W'(top + $urandom_range(3));
        end
        return IDX_W'($urandom);
    endfunction

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (positions_pending != 0) @(posedge aclk);
        repeat (110) @(posedge aclk);
    endtask

    initial begin
        int nf, nt;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        steady       = 1'b0;
        hold_request = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset layout, pass-through
        index_span = 1024;
        send_index('0);
        send_index(IDX_W'(1023));
        send_index(IDX_W'(1024));
        send_index('1);
        send_index(IDX_W'(28'h5555555));
        wait_drained();

        // small edge tiles in both directions: walk the first tile row
        apply_layout(1'b1, 10, 7, 3, 2);
        for (int i = 0; i < 20; i++) send_index(IDX_W'(i));
        wait_drained();

        // fixed settings, then random ones
        for (int phase = 0; phase < 24; phase++) begin
            case (phase)
                0: apply_layout(1'b1, 4096, 65536, 4096, 65536);
                1: apply_layout(1'b1, 8191, 131071, 8191, 131071);
                2: apply_layout(1'b1, 0, 0, 0, 0);
                3: apply_layout(1'b1, 5, 9, 4096, 65536);
                4: apply_layout(1'b0, 100, 37, 7, 5);
                5: apply_layout(1'b1, 4096, 65536, 1, 1);
                6: apply_layout(1'b1, 13, 0, 4, 0);
                default: begin
                    nf = ($urandom_range(9) == 0) ? $urandom_range(8191) : $urandom_range(64);
                    nt = ($urandom_range(9) == 0) ? $urandom_range(131071)
                                                  : $urandom_range(64);
                    apply_layout($urandom_range(5) != 0, nf, nt,
                                 $urandom_range(nf + 2), $urandom_range(nt + 2));
                    if (phase == 10) reg_write(3'd5, $urandom);
                    if (phase == 11) reg_write(3'd7, $urandom);
                end
            endcase
            steady <= (phase == 8);
            if (phase == 9) hold_request <= 1'b1;
            for (int k = 0; k < ((phase == 9) ? 150 : 50); k++) send_index(pick_index());
            wait_drained();
            steady <= 1'b0;
        end

        while (positions_pending != 0 && cycles < CYCLE_LIMIT) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (mismatches == 0) begin
            $display("chunked_tile_index_remap: match");
        end else begin
            $display("chunked_tile_index_remap: mismatch");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/ctir_pkg.sv
rtl/ctir_div.sv
rtl/ctir_cfg.sv
rtl/chunked_tile_index_remap.sv
tb/ctir_checker.sv
tb/testbench.sv
